// File: sv/ssr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the streaming substring replacer.
// No dependencies; imported by every module of the block.
package ssr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int BYTE_W          = 8;
   localparam int WORD_W          = MAX_PATTERN * BYTE_W;
   localparam int LEN_W           = 4;
   localparam int FILL_W          = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = 2;
   localparam int QCNT_W          = 3;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]  pattern_len;
      logic [WORD_W-1:0] repl_bytes;
      logic [LEN_W-1:0]  repl_len;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [LEN_W-1:0]  count;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    full;
      cmd_type head;
   } queue_status_type;

endpackage

// File: sv/ssr_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, keeps the match window, emits at most one command a beat.
// Depends on ssr_pkg.
module ssr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   input  ssr_pkg::cfg_type  cfg,
   input  logic              win_clear,
   input  logic              q_full,
   output logic              push,
   output ssr_pkg::cmd_type  push_cmd
);
   import ssr_pkg::*;

   logic [BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [BYTE_W-1:0] win_new [MAX_PATTERN];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [LEN_W-1:0]  new_fill;
   logic              accept;
   logic              full;
   logic              match;
   logic [WORD_W-1:0] win_word;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign new_fill  = {1'b0, fill_ff} + LEN_W'(1);
   assign full      = (new_fill == cfg.pattern_len);

   always_comb begin
      win_new = win_ff;
      win_new[fill_ff] = req_in_byte;
      match = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         win_word[k*BYTE_W +: BYTE_W] = win_new[k];
         if ((LEN_W'(k) < cfg.pattern_len) &&
             (win_new[k] != cfg.pattern_bytes[k*BYTE_W +: BYTE_W])) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      push_cmd.last = req_in_last;
      push_cmd.data = win_word;
      win_in        = win_new;
      fill_in       = fill_ff;
      if (full && match) begin
         push_cmd.data  = cfg.repl_bytes;
         push_cmd.count = cfg.repl_len;
         fill_in        = '0;
      end else if (full) begin
         push_cmd.count = req_in_last ? new_fill : LEN_W'(1);
         for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            win_in[k] = win_new[k+1];
         end
         fill_in = FILL_W'(cfg.pattern_len - LEN_W'(1));
      end else begin
         push_cmd.count = req_in_last ? new_fill : '0;
         fill_in        = new_fill[FILL_W-1:0];
      end
      if (req_in_last) begin
         fill_in = '0;
      end
      push = accept && ((push_cmd.count != '0) || req_in_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (win_clear) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// File: sv/ssr_queue.sv
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on ssr_pkg.
module ssr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ssr_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output ssr_pkg::queue_status_type status
);
   import ssr_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_pop;

   assign do_pop       = pop && (count_ff != '0);
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/ssr_back.sv
`timescale 1ns / 1ps
// Back end: expands queued commands into result beats through an output register.
// Depends on ssr_pkg.
module ssr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ssr_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_out_last
);
   import ssr_pkg::*;

   logic [FILL_W-1:0] idx_ff;
   logic [FILL_W-1:0] idx_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [BYTE_W-1:0] rsp_byte_in;
   logic              rsp_bvalid_ff;
   logic              rsp_bvalid_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;
   logic              out_free;
   logic              fire;
   logic              step_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = q_status.valid && out_free;
   assign step_last = (q_status.head.count == '0) ||
                      ({1'b0, idx_ff} == q_status.head.count - LEN_W'(1));
   assign pop       = fire && step_last;

   always_comb begin
      rsp_valid_in  = out_free ? q_status.valid : rsp_valid_ff;
      rsp_byte_in   = q_status.head.data[{idx_ff, 3'b000} +: BYTE_W];
      rsp_bvalid_in = (q_status.head.count != '0);
      rsp_last_in   = q_status.head.last && step_last;
      if (!rsp_bvalid_in) begin
         rsp_byte_in = '0;
      end
      idx_in = idx_ff;
      if (fire) begin
         idx_in = step_last ? '0 : idx_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_bvalid_ff <= rsp_bvalid_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule

// File: sv/stream_substring_replace.sv
`timescale 1ns / 1ps
// Streaming substring replacer, top level: control registers, front, queue, back.
// Depends on ssr_pkg, ssr_front, ssr_queue, ssr_back.
//
// Usage:
//   req_*  : source text, one byte per beat, req_in_last on the final byte.
//   rsp_*  : edited text, one byte per beat; rsp_byte_valid low marks a bare
//            end beat, rsp_out_last marks the final beat of a text.
//   csr_*  : write-only registers (pattern, pattern length, replacement,
//            replacement length); write only while the block is idle.
//            Writing the pattern length drops any bytes held in the window.
//   Throughput: one source byte per cycle while req_ready is high. Each
//   matched pattern costs replacement-length result beats, and a final byte
//   costs as many beats as bytes it flushes; a four-entry command queue
//   absorbs this. Source beats pass the queue, then the result register.
//   Receiver stall: the result register holds; the queue fills and req_ready
//   drops once it is full.
//   Reset: synchronous; empties window and queue, pattern length back to one,
//   the other control registers to zero.
module stream_substring_replace (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_out_last,
   input  logic                   csr_we,
   input  ssr_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_wdata
);
   import ssr_pkg::*;

   logic [WORD_W-1:0] pat_bytes_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   logic [WORD_W-1:0] rep_bytes_ff;
   logic [LEN_W-1:0]  rep_len_ff;
   cfg_type           cfg;
   logic              win_clear;
   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   queue_status_type  q_status;

   assign win_clear = csr_we && (csr_index == CSR_PATTERN_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= LEN_W'(1);
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      pat_bytes_ff <= csr_wdata;
            CSR_PATTERN_LENGTH:     pat_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: rep_len_ff   <= csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      cfg.pattern_bytes = pat_bytes_ff;
      cfg.repl_bytes    = rep_bytes_ff;
      cfg.pattern_len   = pat_len_ff;
      if (pat_len_ff == '0) begin
         cfg.pattern_len = LEN_W'(1);
      end else if (pat_len_ff > LEN_W'(MAX_PATTERN)) begin
         cfg.pattern_len = LEN_W'(MAX_PATTERN);
      end
      cfg.repl_len = rep_len_ff;
      if (rep_len_ff > LEN_W'(MAX_REPLACEMENT)) begin
         cfg.repl_len = LEN_W'(MAX_REPLACEMENT);
      end
   end

   ssr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .cfg         (cfg),
      .win_clear   (win_clear),
      .q_full      (q_status.full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   ssr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .status   (q_status)
   );

   ssr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_last   (rsp_out_last)
   );

`ifndef SYNTHESIS
   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_last) |=> q_status.valid)
      else $error("final source beat left no queued command");

   a_empty_cmd_is_last: assert property (@(posedge clock) disable iff (reset)
      q_status.valid |-> ((q_status.head.count != '0) || q_status.head.last))
      else $error("queued command with no bytes and no end mark");

   a_cmd_count_range: assert property (@(posedge clock) disable iff (reset)
      q_status.valid |-> (q_status.head.count <= LEN_W'(MAX_PATTERN)))
      else $error("queued command byte count out of range");

   a_bare_beat_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_out_last)
      else $error("bare result beat without end mark");
`endif

endmodule
